// ===== sv/xts_pkg.sv =====
// Shared types, character codes and defaults for the XML tag stream scanner.
package xts_pkg;

    // Default widths for the position counters and the nesting level
    localparam int POS_WIDTH_DEF   = 32;
    localparam int LEVEL_WIDTH_DEF = 16;

    // Delimiter characters
    localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_QUEST = 8'h3F;  // '?'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
    localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

    // Saturation limit for the name offset and length
    localparam logic [15:0] REL_MAX = 16'hFFFF;

    // Scan phase within the document
    typedef enum logic [1:0] {
        PH_OUTSIDE,
        PH_KIND,
        PH_NAME,
        PH_REST
    } t_phase;

    // Tag kind codes
    typedef enum logic [1:0] {
        KIND_START,
        KIND_END,
        KIND_HEADER,
        KIND_EMPTY
    } t_kind;

    // One result request
    typedef struct packed {
        logic        tag_found;
        t_kind       tag_kind;
        logic [15:0] nest_level;
        logic [31:0] tag_offset;
        logic [31:0] tag_span;
        logic [15:0] name_offset;
        logic [15:0] name_length;
        logic        doc_done;
    } t_result;

endpackage

// ===== sv/xts_core.sv =====
// Scanner core: tag phase state and the per-byte update and result build.
module xts_core #(
    parameter int POS_WIDTH   = xts_pkg::POS_WIDTH_DEF,
    parameter int LEVEL_WIDTH = xts_pkg::LEVEL_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_doc_byte,
    input  logic             i_last_byte,
    output logic             o_has_result,
    output xts_pkg::t_result o_result
);

    xts_pkg::t_phase         r_phase, n_phase;
    logic [POS_WIDTH-1:0]    r_pos;
    logic [POS_WIDTH-1:0]    r_open, n_open;
    xts_pkg::t_kind          r_kind, n_kind;
    logic [15:0]             r_start, n_start;
    logic [15:0]             r_end, n_end;
    logic [7:0]              r_prev;
    logic [LEVEL_WIDTH-1:0]  r_level;
    logic                    r_prev_start;

    logic [POS_WIDTH-1:0]    diff;
    logic [POS_WIDTH-1:0]    span_pos;
    logic [64:0]             rel_ext;
    logic [15:0]             rel_after;
    logic                    is_name;
    logic                    closed;
    logic                    name_step;
    logic [15:0]             start_base;
    logic [15:0]             end_base;
    xts_pkg::t_kind          cur_kind;
    logic [LEVEL_WIDTH-1:0]  lvl_inc;
    logic [LEVEL_WIDTH-1:0]  lvl;
    logic [63:0]             open_ext;
    logic [63:0]             span_ext;
    logic [31:0]             lvl_ext;

    // Offset of the byte after this one, relative to '<', saturating
    assign diff      = r_pos - r_open;
    assign span_pos  = diff + {{(POS_WIDTH-1){1'b0}}, 1'b1};
    assign rel_ext   = 65'(diff) + 65'd1;
    assign rel_after = (rel_ext > 65'(xts_pkg::REL_MAX)) ? xts_pkg::REL_MAX : rel_ext[15:0];

    // A name byte is above space and neither '>' nor '/'
    assign is_name = (i_doc_byte > xts_pkg::CH_SPACE) && (i_doc_byte != xts_pkg::CH_CLOSE)
                     && (i_doc_byte != xts_pkg::CH_SLASH);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            xts_pkg::PH_OUTSIDE: begin
                if (i_doc_byte == xts_pkg::CH_OPEN) n_phase = xts_pkg::PH_KIND;
            end
            xts_pkg::PH_KIND: begin
                if (i_doc_byte == xts_pkg::CH_SLASH || i_doc_byte == xts_pkg::CH_QUEST) begin
                    n_phase = xts_pkg::PH_NAME;
                end else if (is_name) begin
                    n_phase = xts_pkg::PH_NAME;
                end else if (i_doc_byte == xts_pkg::CH_CLOSE) begin
                    n_phase = xts_pkg::PH_OUTSIDE;
                end else begin
                    n_phase = xts_pkg::PH_REST;
                end
            end
            xts_pkg::PH_NAME: begin
                if (is_name) begin
                    n_phase = xts_pkg::PH_NAME;
                end else if (i_doc_byte == xts_pkg::CH_CLOSE) begin
                    n_phase = xts_pkg::PH_OUTSIDE;
                end else begin
                    n_phase = xts_pkg::PH_REST;
                end
            end
            xts_pkg::PH_REST: begin
                if (i_doc_byte == xts_pkg::CH_CLOSE) n_phase = xts_pkg::PH_OUTSIDE;
            end
            default: n_phase = xts_pkg::PH_OUTSIDE;
        endcase
    end

    // Tag fields: open position, kind, name start and length, close detect
    always_comb begin
        closed     = 1'b0;
        name_step  = 1'b0;
        n_open     = r_open;
        n_kind     = r_kind;
        start_base = r_start;
        end_base   = r_end;
        n_start    = r_start;
        n_end      = r_end;
        unique case (r_phase)
            xts_pkg::PH_OUTSIDE: begin
                if (i_doc_byte == xts_pkg::CH_OPEN) n_open = r_pos;
            end
            xts_pkg::PH_KIND: begin
                if (i_doc_byte == xts_pkg::CH_SLASH) begin
                    n_kind  = xts_pkg::KIND_END;
                    n_start = rel_after;
                    n_end   = 16'd0;
                end else if (i_doc_byte == xts_pkg::CH_QUEST) begin
                    n_kind  = xts_pkg::KIND_HEADER;
                    n_start = rel_after;
                    n_end   = 16'd0;
                end else begin
                    // the kind byte is already the first name byte
                    n_kind     = xts_pkg::KIND_START;
                    name_step  = 1'b1;
                    start_base = 16'd1;
                    end_base   = 16'd0;
                end
            end
            xts_pkg::PH_NAME: name_step = 1'b1;
            xts_pkg::PH_REST: closed = (i_doc_byte == xts_pkg::CH_CLOSE);
            default: closed = 1'b0;
        endcase

        // name byte: grow the name, restart after a namespace colon
        if (name_step) begin
            n_start = start_base;
            n_end   = end_base;
            if (is_name) begin
                n_end = (end_base == xts_pkg::REL_MAX) ? end_base : end_base + 16'd1;
                if (i_doc_byte == xts_pkg::CH_COLON) begin
                    n_start = rel_after;
                    n_end   = 16'd0;
                end
            end else begin
                closed = (i_doc_byte == xts_pkg::CH_CLOSE);
            end
        end
    end

    // Kind and nesting level of a closing tag
    assign cur_kind = (r_prev == xts_pkg::CH_SLASH) ? xts_pkg::KIND_EMPTY : n_kind;
    assign lvl_inc  = (r_prev_start && (r_level != {LEVEL_WIDTH{1'b1}}))
                      ? r_level + {{(LEVEL_WIDTH-1){1'b0}}, 1'b1} : r_level;
    assign lvl      = (cur_kind == xts_pkg::KIND_END && lvl_inc != '0)
                      ? lvl_inc - {{(LEVEL_WIDTH-1){1'b0}}, 1'b1} : lvl_inc;

    assign open_ext = 64'(r_open);
    assign span_ext = 64'(span_pos);
    assign lvl_ext  = 32'(lvl);

    // Result request
    always_comb begin
        o_result = '0;
        if (closed) begin
            o_result.tag_found   = 1'b1;
            o_result.tag_kind    = cur_kind;
            o_result.nest_level  = lvl_ext[15:0];
            o_result.tag_offset  = open_ext[31:0];
            o_result.tag_span    = span_ext[31:0];
            o_result.name_offset = n_start;
            o_result.name_length = n_end;
        end
        o_result.doc_done = i_last_byte;
    end

    assign o_has_result = closed || i_last_byte;

    // State update; the final byte returns everything to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= xts_pkg::PH_OUTSIDE;
            r_pos        <= '0;
            r_open       <= '0;
            r_kind       <= xts_pkg::KIND_START;
            r_start      <= '0;
            r_end        <= '0;
            r_prev       <= '0;
            r_level      <= '0;
            r_prev_start <= 1'b0;
        end else if (i_fire) begin
            if (i_last_byte) begin
                r_phase      <= xts_pkg::PH_OUTSIDE;
                r_pos        <= '0;
                r_open       <= '0;
                r_kind       <= xts_pkg::KIND_START;
                r_start      <= '0;
                r_end        <= '0;
                r_prev       <= '0;
                r_level      <= '0;
                r_prev_start <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_pos   <= r_pos + {{(POS_WIDTH-1){1'b0}}, 1'b1};
                r_open  <= n_open;
                r_kind  <= n_kind;
                r_start <= n_start;
                r_end   <= n_end;
                r_prev  <= i_doc_byte;
                if (closed) begin
                    r_level      <= lvl;
                    r_prev_start <= (cur_kind == xts_pkg::KIND_START);
                end
            end
        end
    end

    // The final byte clears the scan
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_last_byte |=> r_phase == xts_pkg::PH_OUTSIDE && r_pos == '0 && r_level == '0)
        else $error("scan state not cleared after final byte");

    // A completed tag always leaves the scan outside any tag
    a_close_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && closed |=> r_phase == xts_pkg::PH_OUTSIDE)
        else $error("phase not outside after a completed tag");

    // Local name starts after the '<'
    a_name_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.tag_found |-> o_result.name_offset != 16'd0)
        else $error("tag with zero name offset");

endmodule

// ===== sv/xts_out_reg.sv =====
// Result register that holds one request toward the downstream side.
module xts_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  xts_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_valid,
    output logic             o_free,
    output xts_pkg::t_result o_result
);

    logic             r_valid;
    xts_pkg::t_result r_result;

    // Space when empty or when the held request leaves this cycle
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== sv/xml_tag_stream_scanner.sv =====
// Top level of the XML tag stream scanner: input register, core, result register.
// A byte that gives a result passes the input register and then the result register before o_valid rises.
// Throughput: one byte per cycle, unless a result waits for room in the result register (o_stall).
// Bytes that give no result pass without using the result register.
// Reset: synchronous active-low i_rst_n clears both registers and the scan state.
module xml_tag_stream_scanner #(
    parameter int POS_WIDTH   = xts_pkg::POS_WIDTH_DEF,
    parameter int LEVEL_WIDTH = xts_pkg::LEVEL_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_doc_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_tag_found,
    output logic [1:0]  o_tag_kind,
    output logic [15:0] o_nest_level,
    output logic [31:0] o_tag_offset,
    output logic [31:0] o_tag_span,
    output logic [15:0] o_name_offset,
    output logic [15:0] o_name_length,
    output logic        o_doc_done
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             in_free;
    logic             fire;
    logic             has_result;
    logic             out_free;
    xts_pkg::t_result core_result;
    xts_pkg::t_result out_result;

    // A byte moves on when it makes no result or the result register has room
    assign fire    = r_in_valid && (!has_result || out_free);
    assign in_free = !r_in_valid || fire;
    assign o_stall = !in_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_in_byte <= i_doc_byte;
            r_in_last <= i_last_byte;
        end
    end

    xts_core #(
        .POS_WIDTH   (POS_WIDTH),
        .LEVEL_WIDTH (LEVEL_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_doc_byte   (r_in_byte),
        .i_last_byte  (r_in_last),
        .o_has_result (has_result),
        .o_result     (core_result)
    );

    xts_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && has_result),
        .i_result (core_result),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign o_tag_found   = out_result.tag_found;
    assign o_tag_kind    = out_result.tag_kind;
    assign o_nest_level  = out_result.nest_level;
    assign o_tag_offset  = out_result.tag_offset;
    assign o_tag_span    = out_result.tag_span;
    assign o_name_offset = out_result.name_offset;
    assign o_name_length = out_result.name_length;
    assign o_doc_done    = out_result.doc_done;

endmodule
